@@ hw/rtl/sto_pkg.sv @@
// Shared types and constants of the spiral tile order generator.
`default_nettype none

package sto_pkg;

  // Default ranges of the image and tile dimensions
  localparam int DEF_MAX_DIM  = 8192;
  localparam int DEF_MAX_TILE = 256;

  // Register values after reset
  localparam int RESET_IMAGE_WIDTH  = 1024;
  localparam int RESET_IMAGE_HEIGHT = 1024;
  localparam int RESET_TILE_SIZE    = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 2'd2;

  // Spiral heading; the order matters, a turn is heading plus one
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    S_DIV_LOAD,
    S_DIV_RUN,
    S_WALK_INIT,
    S_IDLE,
    S_MUL,
    S_CLIP,
    S_STEP
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/spiral_tile_order_core.sv @@
// Spiral tile order generator: grid setup, spiral walk and tile clipping.
`default_nettype none

// Hands out the render tiles of an image in a spiral that starts at the
// center tile of the grid (columns = ceil(width / tile), rows likewise).
// Each input transaction asks for one tile (restart = 1 first rewinds the
// spiral) and produces exactly one output transaction: the tile's pixel
// offset and its size clipped at the right and bottom image edges, or
// has_tile = 0 with all fields zero once every tile has been handed out.
// Width, height and tile size are clamped to 1..MAX_DIM and 1..MAX_TILE.
// After reset and after every register write the block computes the
// grid with one shared restoring divider, one quotient bit per cycle,
// columns first and rows second, then sets up the walk; input stays
// stalled meanwhile. An accepted request passes through the offset
// multiply and the clip (held while the output register is full); then
// the walk unit examines spiral candidates to find the next in-grid tile
// (one per cycle, at least one; none for the last tile and when done)
// before the block is ready again. A restart first rewinds the walk.
// The result sits in an output register, so a new request is taken while
// the previous result still waits for the consumer.
module spiral_tile_order_core #(
  parameter int MAX_DIM  = sto_pkg::DEF_MAX_DIM,
  parameter int MAX_TILE = sto_pkg::DEF_MAX_TILE,
  localparam int DIM_W  = $clog2(MAX_DIM + 1),
  localparam int TILE_W = $clog2(MAX_TILE + 1),
  localparam int XW     = $clog2(MAX_DIM),
  localparam int CFG_W  = (DIM_W > TILE_W) ? DIM_W : TILE_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [sto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          restart,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               has_tile,
  output logic [XW-1:0]                      tile_x,
  output logic [XW-1:0]                      tile_y,
  output logic [TILE_W-1:0]                  tile_width,
  output logic [TILE_W-1:0]                  tile_height
);

  localparam int NUM_W   = $clog2(MAX_DIM + MAX_TILE);  // ceil-division numerator
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int CW      = DIM_W + 1;                   // two's complement grid coordinate
  localparam int TILES_W = 2 * DIM_W;
  localparam int PROD_W  = DIM_W + TILE_W;

  // Configuration registers
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [TILE_W-1:0] tile_size;

  // Clamped dimensions
  logic [DIM_W-1:0]  w_c;
  logic [DIM_W-1:0]  h_c;
  logic [TILE_W-1:0] t_c;

  // Grid and walk state
  logic [DIM_W-1:0]   grid_cols;
  logic [DIM_W-1:0]   grid_rows;
  logic [CW-1:0]      cur_col;
  logic [CW-1:0]      cur_row;
  sto_pkg::dir_t      heading;
  logic [CW-1:0]      steps_remaining;
  logic [CW-1:0]      leg_length;
  logic [TILES_W-1:0] tiles_remaining;

  // Shared divider
  logic              div_sel;     // 0: columns, 1: rows
  logic [NUM_W-1:0]  div_quo;
  logic [TILE_W-1:0] div_rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [TILE_W:0]   rem_sh;
  logic              rem_ge;
  logic [TILE_W:0]   rem_sub;
  logic [NUM_W-1:0]  quo_next;
  logic [NUM_W-1:0]  numer;

  // Tile offset products
  logic [PROD_W-1:0] x_prod;
  logic [PROD_W-1:0] y_prod;
  logic [DIM_W-1:0]  x_pos;
  logic [DIM_W-1:0]  y_pos;
  logic [CFG_W-1:0]  tw_full;
  logic [CFG_W-1:0]  th_full;
  logic [TILE_W-1:0] tw_clip;
  logic [TILE_W-1:0] th_clip;

  // Walk step
  logic [CW-1:0]      col_next;
  logic [CW-1:0]      row_next;
  sto_pkg::dir_t      heading_next;
  logic [CW-1:0]      steps_next;
  logic [CW-1:0]      leg_next;
  logic [CW-1:0]      steps_dec;
  logic               step_inside;
  logic [TILES_W-1:0] tiles_prod;

  // Control
  sto_pkg::state_t state;
  sto_pkg::state_t state_next;
  logic            pending;       // restart request waits behind walk init
  logic            cfg_hit;
  logic            in_take;
  logic            out_free;

  // Clamp registers into their legal ranges
  always_comb begin
    if (image_width == '0) begin
      w_c = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_DIM)) begin
      w_c = DIM_W'(MAX_DIM);
    end else begin
      w_c = image_width;
    end
    if (image_height == '0) begin
      h_c = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_DIM)) begin
      h_c = DIM_W'(MAX_DIM);
    end else begin
      h_c = image_height;
    end
    if (tile_size == '0) begin
      t_c = TILE_W'(1);
    end else if (tile_size > TILE_W'(MAX_TILE)) begin
      t_c = TILE_W'(MAX_TILE);
    end else begin
      t_c = tile_size;
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == sto_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == sto_pkg::REG_IMAGE_HEIGHT ||
                              cfg_index == sto_pkg::REG_TILE_SIZE);

  // Restoring divider: ceil(dim / tile) as (dim + tile - 1) / tile
  assign numer    = (div_sel ? NUM_W'(h_c) : NUM_W'(w_c)) + NUM_W'(t_c) - NUM_W'(1);
  assign rem_sh   = {div_rem, div_quo[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, t_c};
  assign rem_sub  = rem_sh - {1'b0, t_c};
  assign quo_next = {div_quo[NUM_W-2:0], rem_ge};

  // Tile offset: one multiply per axis, clipped from the registered product
  assign x_prod  = cur_col[DIM_W-1:0] * t_c;
  assign y_prod  = cur_row[DIM_W-1:0] * t_c;
  assign tw_full = CFG_W'(w_c) - CFG_W'(x_pos);
  assign th_full = CFG_W'(h_c) - CFG_W'(y_pos);
  assign tw_clip = (tw_full > CFG_W'(t_c)) ? t_c : tw_full[TILE_W-1:0];
  assign th_clip = (th_full > CFG_W'(t_c)) ? t_c : th_full[TILE_W-1:0];

  assign tiles_prod = grid_cols * grid_rows;

  // One spiral candidate: move along the heading, turn at the leg end
  always_comb begin
    col_next = cur_col;
    row_next = cur_row;
    unique case (heading)
      sto_pkg::DIR_RIGHT: col_next = cur_col + CW'(1);
      sto_pkg::DIR_DOWN:  row_next = cur_row + CW'(1);
      sto_pkg::DIR_LEFT:  col_next = cur_col - CW'(1);
      sto_pkg::DIR_UP:    row_next = cur_row - CW'(1);
      default:            col_next = cur_col;
    endcase
    steps_dec    = steps_remaining - CW'(1);
    heading_next = heading;
    leg_next     = leg_length;
    steps_next   = steps_dec;
    if (steps_dec == '0) begin
      heading_next = sto_pkg::dir_t'(heading + 2'd1);
      if (heading_next == sto_pkg::DIR_RIGHT || heading_next == sto_pkg::DIR_LEFT) begin
        leg_next = leg_length + CW'(1);
      end
      steps_next = leg_next;
    end
    step_inside = !col_next[CW-1] && !row_next[CW-1] &&
                  (col_next < {1'b0, grid_cols}) && (row_next < {1'b0, grid_rows});
  end

  assign out_free = !out_valid || !out_stall;
  assign in_take  = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sto_pkg::S_DIV_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and stall
  always_comb begin
    state_next = state;
    in_stall   = (state != sto_pkg::S_IDLE) || cfg_we;
    unique case (state)
      sto_pkg::S_DIV_LOAD: begin
        state_next = sto_pkg::S_DIV_RUN;
      end
      sto_pkg::S_DIV_RUN: begin
        if (div_cnt == '0) begin
          state_next = div_sel ? sto_pkg::S_WALK_INIT : sto_pkg::S_DIV_LOAD;
        end
      end
      sto_pkg::S_WALK_INIT: begin
        state_next = pending ? sto_pkg::S_MUL : sto_pkg::S_IDLE;
      end
      sto_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = restart ? sto_pkg::S_WALK_INIT : sto_pkg::S_MUL;
        end
      end
      sto_pkg::S_MUL: begin
        state_next = sto_pkg::S_CLIP;
      end
      sto_pkg::S_CLIP: begin
        if (out_free) begin
          if (tiles_remaining > TILES_W'(1)) begin
            state_next = sto_pkg::S_STEP;
          end else begin
            state_next = sto_pkg::S_IDLE;
          end
        end
      end
      sto_pkg::S_STEP: begin
        if (step_inside) begin
          state_next = sto_pkg::S_IDLE;
        end
      end
      default: state_next = sto_pkg::S_IDLE;
    endcase
    // any register write rebuilds the grid
    if (cfg_hit) begin
      state_next = sto_pkg::S_DIV_LOAD;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(sto_pkg::RESET_IMAGE_WIDTH);
      image_height <= DIM_W'(sto_pkg::RESET_IMAGE_HEIGHT);
      tile_size    <= TILE_W'(sto_pkg::RESET_TILE_SIZE);
      div_sel      <= 1'b0;
      pending      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sto_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
          sto_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
          sto_pkg::REG_TILE_SIZE:    tile_size    <= cfg_data[TILE_W-1:0];
          default:                   image_width  <= image_width;
        endcase
      end
      if (cfg_hit) begin
        div_sel <= 1'b0;
        pending <= 1'b0;
      end else begin
        if (state == sto_pkg::S_DIV_RUN && div_cnt == '0) begin
          div_sel <= !div_sel;
        end
        if (state == sto_pkg::S_IDLE && in_take && restart) begin
          pending <= 1'b1;
        end else if (state == sto_pkg::S_WALK_INIT) begin
          pending <= 1'b0;
        end
      end
      // hold the result until the consumer takes it
      if (state == sto_pkg::S_CLIP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      sto_pkg::S_DIV_LOAD: begin
        div_quo <= numer;
        div_rem <= '0;
        div_cnt <= CNT_W'(NUM_W - 1);
      end
      sto_pkg::S_DIV_RUN: begin
        div_quo <= quo_next;
        div_rem <= rem_ge ? rem_sub[TILE_W-1:0] : rem_sh[TILE_W-1:0];
        div_cnt <= div_cnt - CNT_W'(1);
        if (div_cnt == '0) begin
          if (div_sel) begin
            grid_rows <= quo_next[DIM_W-1:0];
          end else begin
            grid_cols <= quo_next[DIM_W-1:0];
          end
        end
      end
      sto_pkg::S_WALK_INIT: begin
        cur_col         <= {2'b00, grid_cols[DIM_W-1:1]};
        cur_row         <= {2'b00, grid_rows[DIM_W-1:1]};
        heading         <= sto_pkg::DIR_RIGHT;
        steps_remaining <= CW'(1);
        leg_length      <= CW'(1);
        tiles_remaining <= tiles_prod;
      end
      sto_pkg::S_MUL: begin
        x_pos <= x_prod[DIM_W-1:0];
        y_pos <= y_prod[DIM_W-1:0];
      end
      sto_pkg::S_CLIP: begin
        if (out_free) begin
          if (tiles_remaining == '0) begin
            has_tile    <= 1'b0;
            tile_x      <= '0;
            tile_y      <= '0;
            tile_width  <= '0;
            tile_height <= '0;
          end else begin
            has_tile        <= 1'b1;
            tile_x          <= x_pos[XW-1:0];
            tile_y          <= y_pos[XW-1:0];
            tile_width      <= tw_clip;
            tile_height     <= th_clip;
            tiles_remaining <= tiles_remaining - TILES_W'(1);
          end
        end
      end
      sto_pkg::S_STEP: begin
        cur_col         <= col_next;
        cur_row         <= row_next;
        heading         <= heading_next;
        steps_remaining <= steps_next;
        leg_length      <= leg_next;
      end
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  ap_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_tile |->
      tile_x == '0 && tile_y == '0 && tile_width == '0 && tile_height == '0)
    else $error("done result carries nonzero fields");

  ap_tile_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_tile |->
      tile_width != '0 && tile_height != '0 && tile_width <= t_c && tile_height <= t_c)
    else $error("tile size outside 1..tile_size");

  ap_mul_inside: assert property (@(posedge clk) disable iff (rst)
    state == sto_pkg::S_MUL && tiles_remaining != '0 |->
      !cur_col[CW-1] && !cur_row[CW-1] &&
      cur_col < {1'b0, grid_cols} && cur_row < {1'b0, grid_rows})
    else $error("tile position outside the grid");

  ap_step_count: assert property (@(posedge clk) disable iff (rst)
    state == sto_pkg::S_STEP |-> steps_remaining != '0 && leg_length != '0)
    else $error("spiral leg counter reached zero");

  ap_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> state == sto_pkg::S_DIV_LOAD && !div_sel && !out_valid || $past(out_valid))
    else $error("register write did not restart grid setup");
`endif

endmodule

`default_nettype wire

@@ dv/tb_spiral_tile_order_core.sv @@
// Self-checking testbench of the spiral tile order generator core.
`timescale 1ns / 100ps

module tb_spiral_tile_order_core;

  // Random requests after the directed rows
  localparam int ITEMS_RANDOM = 1800;
  // Watchdog: far above the slowest legal run
  localparam int CYCLE_LIMIT  = 1500000;
  // Long consumer hold-off, started once the run is under way
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;
  // The last requests run with no idling on either side
  localparam int QUIET_TAIL   = 250;
  // Index past the three registers; the block must ignore writes to it
  localparam logic [sto_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        has;
    logic [12:0] x;
    logic [12:0] y;
    logic [8:0]  w;
    logic [8:0]  h;
  } tile_t;

  // One directed row: a register write or a tile request, with a typed-in
  // result where the answer is obvious
  typedef struct packed {
    logic                          is_write;
    logic [sto_pkg::CFG_IDX_W-1:0] idx;
    logic [13:0]                   data;
    logic                          rs;
    logic                          typed;
    tile_t                         want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [sto_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [13:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          restart = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          has_tile;
  logic [12:0]                   tile_x;
  logic [12:0]                   tile_y;
  logic [8:0]                    tile_width;
  logic [8:0]                    tile_height;

  spiral_tile_order_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .has_tile    (has_tile),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_width  (tile_width),
    .tile_height (tile_height)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Spiral predictor: registers, grid and walk position
  // ---------------------------------------------------------------------
  logic [13:0]   img_width_reg;
  logic [13:0]   img_height_reg;
  logic [8:0]    tile_size_reg;
  int unsigned   grid_cols;
  int unsigned   grid_rows;
  int            col_pos;
  int            row_pos;
  sto_pkg::dir_t heading;
  int unsigned   leg_steps;
  int unsigned   leg_len;
  int unsigned   tiles_left;

  tile_t       pending_tiles[$];   // results owed by the block, oldest first
  dir_row_t    directed_rows[$];
  int          requests_done = 0;
  int          fail_count = 0;
  int          idle_mode = 0;      // 0 none, 1 light, 2 heavy
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          burst_left = 0;
  tile_t       got_tile;
  tile_t       want_tile;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Rebuild the grid from the registers and park the walk on the center tile
  function automatic void rewind_spiral();
    int unsigned w;
    int unsigned h;
    int unsigned t;
    w = clamp_dim(img_width_reg, sto_pkg::DEF_MAX_DIM);
    h = clamp_dim(img_height_reg, sto_pkg::DEF_MAX_DIM);
    t = clamp_dim(tile_size_reg, sto_pkg::DEF_MAX_TILE);
    grid_cols  = (w + t - 1) / t;
    grid_rows  = (h + t - 1) / t;
    col_pos    = int'(grid_cols / 2);
    row_pos    = int'(grid_rows / 2);
    heading    = sto_pkg::DIR_RIGHT;
    leg_steps  = 1;
    leg_len    = 1;
    tiles_left = grid_cols * grid_rows;
  endfunction

  function automatic bit off_grid();
    return col_pos < 0 || row_pos < 0 ||
           col_pos >= int'(grid_cols) || row_pos >= int'(grid_rows);
  endfunction

  // Step along the spiral until the position lands inside the grid
  function automatic void walk_on();
    logic [1:0] nxt;
    do begin
      case (heading)
        sto_pkg::DIR_RIGHT: col_pos++;
        sto_pkg::DIR_DOWN:  row_pos++;
        sto_pkg::DIR_LEFT:  col_pos--;
        default:            row_pos--;
      endcase
      leg_steps--;
      if (leg_steps == 0) begin
        nxt = heading + 2'd1;
        heading = sto_pkg::dir_t'(nxt);
        // legs grow on every turn onto a horizontal heading
        if (heading == sto_pkg::DIR_RIGHT || heading == sto_pkg::DIR_LEFT) leg_len++;
        leg_steps = leg_len;
      end
    end while (off_grid());
  endfunction

  function automatic void apply_reg(logic [sto_pkg::CFG_IDX_W-1:0] idx, logic [13:0] d);
    case (idx)
      sto_pkg::REG_IMAGE_WIDTH:  img_width_reg = d;
      sto_pkg::REG_IMAGE_HEIGHT: img_height_reg = d;
      sto_pkg::REG_TILE_SIZE:    tile_size_reg = d[8:0];
      default:                   return;
    endcase
    rewind_spiral();
  endfunction

  // Tile handed out for one request; moves the walk on
  function automatic tile_t predict_tile(bit rs);
    tile_t       r;
    int unsigned w;
    int unsigned h;
    int unsigned t;
    int unsigned x;
    int unsigned y;
    int unsigned tw;
    int unsigned th;
    w = clamp_dim(img_width_reg, sto_pkg::DEF_MAX_DIM);
    h = clamp_dim(img_height_reg, sto_pkg::DEF_MAX_DIM);
    t = clamp_dim(tile_size_reg, sto_pkg::DEF_MAX_TILE);
    r = '0;
    if (rs) rewind_spiral();
    if (tiles_left == 0) return r;
    x  = int'(col_pos) * t;
    y  = int'(row_pos) * t;
    tw = w - x;
    th = h - y;
    if (tw > t) tw = t;
    if (th > t) th = t;
    r.has = 1'b1;
    r.x   = x[12:0];
    r.y   = y[12:0];
    r.w   = tw[8:0];
    r.h   = th[8:0];
    tiles_left--;
    // the walk stays put after the last tile
    if (tiles_left != 0) walk_on();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------
  function automatic void add_write(logic [sto_pkg::CFG_IDX_W-1:0] idx, logic [13:0] d);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = d;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_request(bit rs, bit typed, tile_t want);
    dir_row_t r;
    r = '0;
    r.rs = rs;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offer one request, hold it until taken, then log what it must return
  task automatic request_tile(bit rs, bit typed, tile_t want);
    tile_t p;
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    p = predict_tile(rs);
    pending_tiles.push_back(typed ? want : p);
    requests_done++;
    if ((idle_mode == 1 && $urandom_range(0, 5) == 0) ||
        (idle_mode == 2 && $urandom_range(0, 1) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Drain the block: all results back and the walk unit ready again
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    do @(posedge clk); while (in_stall);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [sto_pkg::CFG_IDX_W-1:0] idx, logic [13:0] d);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic logic [13:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return 14'd8192;
      3:       return 14'd8193;
      4:       return 14'h3FFF;
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic [13:0] pick_tile();
    case ($urandom_range(0, 5))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return 14'd256;
      3:       return 14'd257;
      4:       return 14'h3FFF;   // upper data bits are dropped, 511 remains
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  initial begin
    dir_row_t    row;
    int          last_request;
    int          kind;
    int unsigned t;
    int unsigned cap;
    int unsigned n;

    img_width_reg  = 14'(sto_pkg::RESET_IMAGE_WIDTH);
    img_height_reg = 14'(sto_pkg::RESET_IMAGE_HEIGHT);
    tile_size_reg  = 9'(sto_pkg::RESET_TILE_SIZE);
    rewind_spiral();

    // Reset values: 32 x 32 grid of 32-pixel tiles, start at the center
    add_request(1'b0, 1'b1, tile_t'{1'b1, 13'd512, 13'd512, 9'd32, 9'd32});
    add_request(1'b0, 1'b0, '0);
    add_request(1'b1, 1'b1, tile_t'{1'b1, 13'd512, 13'd512, 9'd32, 9'd32});
    // Single-tile grid: one tile, then done, then restart brings it back
    add_write(sto_pkg::REG_IMAGE_WIDTH, 14'd1);
    add_write(sto_pkg::REG_IMAGE_HEIGHT, 14'd1);
    add_write(sto_pkg::REG_TILE_SIZE, 14'd1);
    add_request(1'b0, 1'b1, tile_t'{1'b1, 13'd0, 13'd0, 9'd1, 9'd1});
    add_request(1'b0, 1'b1, '0);
    add_request(1'b1, 1'b1, tile_t'{1'b1, 13'd0, 13'd0, 9'd1, 9'd1});
    // Zero width and tile clamp to 1, oversized height clamps to 8192
    add_write(sto_pkg::REG_IMAGE_WIDTH, 14'd0);
    add_write(sto_pkg::REG_IMAGE_HEIGHT, 14'h3FFF);
    add_write(sto_pkg::REG_TILE_SIZE, 14'd0);
    add_request(1'b0, 1'b1, tile_t'{1'b1, 13'd0, 13'd4096, 9'd1, 9'd1});
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    // Largest image and tile, with out-of-range values clamped
    add_write(sto_pkg::REG_IMAGE_WIDTH, 14'h3FFF);
    add_write(sto_pkg::REG_IMAGE_HEIGHT, 14'd8192);
    add_write(sto_pkg::REG_TILE_SIZE, 14'h3FFF);
    add_request(1'b0, 1'b1, tile_t'{1'b1, 13'd4096, 13'd4096, 9'd256, 9'd256});
    // 4 x 2 grid clipped on both edges, walked to the end
    add_write(sto_pkg::REG_IMAGE_WIDTH, 14'd100);
    add_write(sto_pkg::REG_IMAGE_HEIGHT, 14'd50);
    add_write(sto_pkg::REG_TILE_SIZE, 14'd32);
    add_request(1'b0, 1'b1, tile_t'{1'b1, 13'd64, 13'd32, 9'd32, 9'd18});
    add_request(1'b0, 1'b0, '0);
    // write to the spare index: the walk must carry on untouched
    add_write(REG_SPARE, 14'h2AAA);
    repeat (6) add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b1, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: light idling so handshakes see some gaps
    idle_mode = 1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) write_reg(row.idx, row.data);
      else request_tile(row.rs, row.typed, row.want);
    end

    // Random phases: new geometry (mostly small grids so done shows up),
    // spare-index writes, or plain continuation of the current walk
    last_request = requests_done + ITEMS_RANDOM;
    while (requests_done < last_request) begin
      kind = $urandom_range(0, 9);
      if (requests_done >= last_request - QUIET_TAIL) idle_mode = 0;
      else idle_mode = $urandom_range(0, 2);
      if (kind <= 5) begin
        t = $urandom_range(1, 64);
        if ($urandom_range(0, 3) != 0) write_reg(sto_pkg::REG_TILE_SIZE, 14'(t));
        write_reg(sto_pkg::REG_IMAGE_WIDTH,
                  14'($urandom_range(1, t * $urandom_range(1, 12))));
        if ($urandom_range(0, 3) != 0)
          write_reg(sto_pkg::REG_IMAGE_HEIGHT,
                    14'($urandom_range(1, t * $urandom_range(1, 12))));
      end else if (kind == 6) begin
        write_reg(sto_pkg::REG_IMAGE_HEIGHT, pick_dim());
        write_reg(sto_pkg::REG_TILE_SIZE, pick_tile());
        write_reg(sto_pkg::REG_IMAGE_WIDTH, pick_dim());
      end else if (kind == 7) begin
        write_reg(REG_SPARE, 14'($urandom_range(0, 16383)));
      end
      cap = tiles_left + 3;
      if (cap > 60) cap = 60;
      n = $urandom_range(1, cap);
      repeat (n) request_tile($urandom_range(0, 19) == 0, 1'b0, '0);
    end

    // Drain, then leave room for any stray result
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** spiral_tile_order_core: PASSED **");
    end else begin
      $display("** spiral_tile_order_core: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random stall bursts plus one long hold-off that lets the
  // output register fill and backs the block up into its request input
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && requests_done >= HOLD_AT && in_valid) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_mode != 0 &&
                 $urandom_range(0, (idle_mode == 2) ? 3 : 11) == 0) begin
      burst_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_miss(string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: want has=%0b x=%0d y=%0d w=%0d h=%0d, got has=%0b x=%0d y=%0d w=%0d h=%0d",
               $realtime, what, want_tile.has, want_tile.x, want_tile.y, want_tile.w,
               want_tile.h, got_tile.has, got_tile.x, got_tile.y, got_tile.w, got_tile.h);
  endtask

  // Check every result transaction against the oldest owed tile
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_tile = {has_tile, tile_x, tile_y, tile_width, tile_height};
      if (pending_tiles.size() == 0) begin
        want_tile = '0;
        report_miss("unexpected result");
      end else begin
        want_tile = pending_tiles.pop_front();
        if (got_tile.has !== want_tile.has || got_tile.x !== want_tile.x ||
            got_tile.y !== want_tile.y || got_tile.w !== want_tile.w ||
            got_tile.h !== want_tile.h)
          report_miss("tile mismatch");
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** spiral_tile_order_core: FAILED **");
      $finish;
    end
  end

endmodule

@@ spiral_tile_order_core.f @@
hw/rtl/sto_pkg.sv
hw/rtl/spiral_tile_order_core.sv
dv/tb_spiral_tile_order_core.sv
